/* src/rqdo_pkg.sv */
// Package for the report queue with drop-oldest overflow.
// Holds the queue depth, field codes, and the item, entry and control struct types.
// No dependencies.
package rqdo_pkg;

	// Queue geometry.
	localparam int QUEUE_DEPTH = 48;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	// Opcodes of an input item.
	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_TOOK = 2'd1;
	localparam logic [1:0] OP_REJECT = 2'd2;

	// Report ids and their body lengths.
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_KEYBOARD = 2'd1;
	localparam logic [1:0] KIND_CONSUMER = 2'd2;
	localparam logic [3:0] LEN_NONE = 4'd0;
	localparam logic [3:0] LEN_KEYBOARD = 4'd8;
	localparam logic [3:0] LEN_CONSUMER = 4'd12;

	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] report_kind;
		logic [63:0] body_low;
		logic [31:0] body_high;
	} item_t;

	typedef struct packed {
		logic head_valid;
		logic [1:0] head_kind;
		logic [3:0] head_length;
		logic [63:0] head_body_low;
		logic [31:0] head_body_high;
		logic [5:0] queued_count;
		logic [31:0] drop_count;
		logic [31:0] sent_count;
	} result_t;

	// One stored report: consumer flag and the body.
	typedef struct packed {
		logic consumer;
		logic [63:0] body_low;
		logic [31:0] body_high;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic write_entry;
		logic advance_wr;
		logic advance_rd;
		logic fill_inc;
		logic fill_dec;
		logic drop_inc;
		logic sent_inc;
		logic read_head;
		logic load_result;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic push_req;
		logic resp_req;
		logic took;
		logic empty;
		logic full;
	} status_t;

endpackage

/* src/rqdo_ctrl.sv */
// Controller state machine for the report queue.
// Sequences capture, update, head read and result load; owns the handshakes.
// Depends on rqdo_pkg.
module rqdo_ctrl (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	output logic result_valid,
	input logic result_ready,
	input rqdo_pkg::status_t status,
	output rqdo_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;
	localparam logic [1:0] ST_LOAD = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic result_valid_q;
	logic load_ok;

	assign item_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign load_ok = !result_valid_q || result_ready;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (status.push_req) begin
					cmd.write_entry = 1'b1;
					cmd.advance_wr = 1'b1;
					if (status.full) begin
						cmd.advance_rd = 1'b1;
						cmd.drop_inc = 1'b1;
					end else begin
						cmd.fill_inc = 1'b1;
					end
				end else if (status.resp_req && !status.empty) begin
					cmd.advance_rd = 1'b1;
					cmd.fill_dec = 1'b1;
					cmd.sent_inc = status.took;
				end
				state_d = ST_READ;
			end
			ST_READ: begin
				cmd.read_head = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (load_ok) begin
					cmd.load_result = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The output register is never overwritten while it holds an unsent result.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> (!result_valid_q || result_ready))
		else $error("result overwritten before transfer");

	// At most one of fill increment, fill decrement and drop increment per update.
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.fill_inc, cmd.fill_dec, cmd.drop_inc}))
		else $error("conflicting fill commands");

	// A capture is always followed by the update step.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_EXEC))
		else $error("capture not followed by update");

endmodule

/* src/rqdo_datapath.sv */
// Datapath of the report queue: entry memory, pointers, fill level,
// counters, captured item and output register. Depends on rqdo_pkg.
module rqdo_datapath (
	input logic clk,
	input logic arst_n,
	input rqdo_pkg::item_t item,
	input rqdo_pkg::cmd_t cmd,
	output rqdo_pkg::status_t status,
	output rqdo_pkg::result_t result
);

	localparam logic [rqdo_pkg::PTR_W-1:0] PTR_LAST =
		rqdo_pkg::PTR_W'(rqdo_pkg::QUEUE_DEPTH - 1);
	localparam logic [rqdo_pkg::FILL_W-1:0] FILL_FULL =
		rqdo_pkg::FILL_W'(rqdo_pkg::QUEUE_DEPTH);

	rqdo_pkg::entry_t entry_mem [rqdo_pkg::QUEUE_DEPTH];
	rqdo_pkg::entry_t rd_data_q;
	rqdo_pkg::entry_t wr_entry;
	rqdo_pkg::item_t item_q;
	rqdo_pkg::result_t result_q;
	rqdo_pkg::result_t result_d;
	logic [rqdo_pkg::PTR_W-1:0] wr_ptr_q;
	logic [rqdo_pkg::PTR_W-1:0] rd_ptr_q;
	logic [rqdo_pkg::FILL_W-1:0] fill_q;
	logic [rqdo_pkg::FILL_W+5:0] fill_ext;
	logic [31:0] drop_q;
	logic [31:0] sent_q;
	logic item_consumer;

	// Decode of the captured item.
	assign item_consumer = (item_q.report_kind == rqdo_pkg::KIND_CONSUMER);
	assign status.push_req = (item_q.opcode == rqdo_pkg::OP_PUSH) &&
		((item_q.report_kind == rqdo_pkg::KIND_KEYBOARD) || item_consumer);
	assign status.resp_req = (item_q.opcode == rqdo_pkg::OP_TOOK) ||
		(item_q.opcode == rqdo_pkg::OP_REJECT);
	assign status.took = (item_q.opcode == rqdo_pkg::OP_TOOK);
	assign status.empty = (fill_q == '0);
	assign status.full = (fill_q == FILL_FULL);

	// Keyboard reports store a zero upper body.
	assign wr_entry.consumer = item_consumer;
	assign wr_entry.body_low = item_q.body_low;
	assign wr_entry.body_high = item_consumer ? item_q.body_high : 32'd0;

	// Captured item, no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			entry_mem[wr_ptr_q] <= wr_entry;
		end
		if (cmd.read_head) begin
			rd_data_q <= entry_mem[rd_ptr_q];
		end
	end

	// Pointers, fill level and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
			drop_q <= '0;
			sent_q <= '0;
		end else begin
			if (cmd.advance_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (cmd.advance_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (cmd.fill_inc) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.fill_dec) begin
				fill_q <= fill_q - 1'b1;
			end
			if (cmd.drop_inc) begin
				drop_q <= drop_q + 32'd1;
			end
			if (cmd.sent_inc) begin
				sent_q <= sent_q + 32'd1;
			end
		end
	end

	// Result assembly: head fields read as zero when the queue is empty.
	assign fill_ext = {6'd0, fill_q};
	always_comb begin
		result_d = '0;
		if (!status.empty) begin
			result_d.head_valid = 1'b1;
			result_d.head_kind = rd_data_q.consumer ? rqdo_pkg::KIND_CONSUMER :
				rqdo_pkg::KIND_KEYBOARD;
			result_d.head_length = rd_data_q.consumer ? rqdo_pkg::LEN_CONSUMER :
				rqdo_pkg::LEN_KEYBOARD;
			result_d.head_body_low = rd_data_q.body_low;
			result_d.head_body_high = rd_data_q.body_high;
		end
		result_d.queued_count = fill_ext[5:0];
		result_d.drop_count = drop_q;
		result_d.sent_count = sent_q;
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			result_q <= result_d;
		end
	end
	assign result = result_q;

	// Fill level never exceeds the queue depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_FULL)
		else $error("fill level above depth");

	// Pointers meet exactly when the queue is empty or full.
	assert property (@(posedge clk) disable iff (!arst_n)
		((fill_q == '0) || (fill_q == FILL_FULL)) == (rd_ptr_q == wr_ptr_q))
		else $error("pointers disagree with fill level");

	// An overflow drop leaves the queue full.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop_inc |=> (fill_q == FILL_FULL))
		else $error("drop did not leave queue full");

endmodule

/* src/report_queue_drop_oldest_unit.sv */
// Top level of the report queue with drop-oldest overflow.
// Joins the controller and the datapath. Depends on rqdo_pkg, rqdo_ctrl, rqdo_datapath.
//
//   Channel   Handshake                     Payload
//   item      item_valid / item_ready       item   (rqdo_pkg::item_t)
//   result    result_valid / result_ready   result (rqdo_pkg::result_t)
//
// Each item goes through four steps: capture, queue update with the entry write,
// head read from the entry memory port, and load of the output register.
// One item is in work at a time; the next is taken after the load.
// A result waiting in the output register does not block the next item;
// only its load waits until the held result transfers.
// Reset empties the queue and clears both counters; the entry memory is not cleared.
module report_queue_drop_oldest_unit (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_ready,
	input rqdo_pkg::item_t item,
	output logic result_valid,
	input logic result_ready,
	output rqdo_pkg::result_t result
);

	rqdo_pkg::cmd_t cmd;
	rqdo_pkg::status_t status;

	rqdo_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.cmd(cmd)
	);

	rqdo_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.status(status),
		.result(result)
	);

endmodule
